// File: hdl/wlc_pkg.sv
// wlc_pkg: shared types and constants for the windowed level compressor
// no dependencies; used by every module in hdl
`default_nettype none

package wlc_pkg;

    localparam int MAX_WINDOW_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int WLEN_BITS     = 13;
    localparam int GAIN_BITS     = 17;
    localparam int FRAC_BITS     = 15;

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 17'd32768;
    localparam logic [FRAC_BITS-1:0] ROUND_BIAS = 15'd16384;

    localparam logic [WLEN_BITS-1:0]     WINDOW_LEN_RST   = 13'd441;
    localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RST    = 16'd16384;
    localparam logic [CFG_DATA_BITS-1:0] GAIN_FLOOR_RST   = 16'd16384;
    localparam logic [CFG_DATA_BITS-1:0] ATTACK_STEP_RST  = 16'd328;
    localparam logic [CFG_DATA_BITS-1:0] RELEASE_STEP_RST = 16'd33;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LEN   = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_GAIN_FLOOR   = 3'd2,
        CFG_ATTACK_STEP  = 3'd3,
        CFG_RELEASE_STEP = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_DRAIN  = 1'b1
    } t_kind;

    // result request travelling with the buffer read
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [GAIN_BITS-1:0] gain;
    } t_rd_req;

endpackage

`default_nettype wire

// File: hdl/windowed_level_compressor.sv
// windowed_level_compressor: top level of the windowed level compressor
// instantiates wlc_ctrl, wlc_store and wlc_scale; depends on wlc_pkg
//
// input channel: i_valid / o_stall with i_kind, i_sample_in, i_stream_last;
//   a transfer happens on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with o_sample_out, o_stream_end
// config: i_cfg_wen, i_cfg_idx, i_cfg_wdata, written on any edge with i_cfg_wen high;
//   the user must write only while the block is idle; the block does not enforce it
// one input transfer per cycle is taken while o_stall is low; the gain and window state
//   update in the cycle of the transfer, so throughput is one item per clock without stalls
// a result passes three registers after its input transfer: buffer read register,
//   multiply register, output register
// samples of a window come out one window later, scaled by that window's gain;
//   drain items flush the buffer after the last sample of a stream
// a stalled receiver holds the output register; the three stages still fill,
//   and o_stall rises once no stage can move
// reset (synchronous, active low) restores the default registers, unity gain
//   and an empty window; the sample buffer is not cleared
`default_nettype none

module windowed_level_compressor #(
    parameter int MAX_WINDOW  = wlc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wlc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wen,
    input  wire logic [wlc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [wlc_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_kind,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    input  wire logic                              i_stream_last,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [SAMPLE_BITS-1:0]          o_sample_out,
    output logic                                   o_stream_end
);

    localparam int AW = $clog2(MAX_WINDOW);

    logic                   accept;
    logic                   store_ready;
    logic                   scale_ready;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    wlc_pkg::t_rd_req       req_in;
    wlc_pkg::t_rd_req       req_rd;

    assign o_stall = !store_ready;
    assign accept  = i_valid && store_ready;

    wlc_ctrl #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_sample_in   (i_sample_in),
        .i_stream_last (i_stream_last),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .o_req         (req_in)
    );

    wlc_store #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr  (rd_addr),
        .i_req      (req_in),
        .i_ready_dn (scale_ready),
        .o_ready    (store_ready),
        .o_rd_data  (rd_data),
        .o_req      (req_rd)
    );

    wlc_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (rd_data),
        .i_req        (req_rd),
        .i_stall      (i_stall),
        .o_ready      (scale_ready),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out),
        .o_stream_end (o_stream_end)
    );

endmodule

`default_nettype wire

// File: hdl/wlc_ctrl.sv
// wlc_ctrl: configuration registers, window level tracking and gain update
// issues buffer reads and writes; depends on wlc_pkg
`default_nettype none

module wlc_ctrl #(
    parameter int MAX_WINDOW  = wlc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wlc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wen,
    input  wire logic [wlc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [wlc_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  wire logic                                i_accept,
    input  wire logic                                i_kind,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  wire logic                                i_stream_last,
    output logic                                     o_wr_en,
    output logic [$clog2(MAX_WINDOW)-1:0]            o_wr_addr,
    output logic [SAMPLE_BITS-1:0]                   o_wr_data,
    output logic [$clog2(MAX_WINDOW)-1:0]            o_rd_addr,
    output wlc_pkg::t_rd_req                         o_req
);

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int SUMW = SAMPLE_BITS + AW;
    localparam int LIMW = wlc_pkg::CFG_DATA_BITS + AW + 1;
    localparam int CMPW = (SUMW > LIMW) ? SUMW : LIMW;
    localparam int GW   = wlc_pkg::GAIN_BITS;

    logic [wlc_pkg::WLEN_BITS-1:0]     r_wlen;
    logic [wlc_pkg::CFG_DATA_BITS-1:0] r_thr, r_floor, r_att, r_rel;

    logic [AW-1:0]   r_wpos, n_wpos;
    logic [SUMW-1:0] r_lsum, n_lsum;
    logic [LIMW-1:0] r_lim, n_lim;
    logic [GW-1:0]   r_cgain, n_cgain, r_egain, n_egain;
    logic            r_pfull, n_pfull;
    logic [AW:0]     r_drem, n_drem;
    logic [AW-1:0]   r_dpos, n_dpos;
    logic [AW:0]     r_dsw, n_dsw;

    logic [AW:0]            wl_eff;
    logic [AW:0]            count;
    logic [AW:0]            tail;
    logic                   close_win;
    logic [SAMPLE_BITS-1:0] s_abs;
    logic [SUMW-1:0]        sum;
    logic [CMPW-1:0]        sum_c, lim_c;
    logic [GW-1:0]          floor_g;
    logic signed [GW+1:0]   g_dn;
    logic [GW:0]            g_up;
    logic [GW-1:0]          g_new;

    // effective window length, clamped to 1..MAX_WINDOW
    always_comb begin
        if (r_wlen == '0) begin
            wl_eff = (AW+1)'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            wl_eff = (AW+1)'(MAX_WINDOW);
        end else begin
            wl_eff = (AW+1)'(r_wlen);
        end
    end

    assign count     = {1'b0, r_wpos} + (AW+1)'(1);
    assign close_win = i_stream_last || (count >= wl_eff);
    assign tail      = (r_pfull && (count < wl_eff)) ? (wl_eff - count) : '0;
    assign s_abs     = i_sample_in[SAMPLE_BITS-1] ? (SAMPLE_BITS)'(-i_sample_in)
                                                  : SAMPLE_BITS'(i_sample_in);
    assign sum       = r_lsum + SUMW'(s_abs);
    assign sum_c     = CMPW'(sum);
    assign lim_c     = CMPW'(r_lim);
    assign floor_g   = GW'(r_floor);
    assign g_dn      = $signed({2'b00, r_cgain}) - $signed((GW+2)'(r_att));
    assign g_up      = {1'b0, r_cgain} + (GW+1)'(r_rel);

    // one gain step per closed window
    always_comb begin
        g_new = r_cgain;
        if ((sum_c > lim_c) && (r_cgain > floor_g)) begin
            if (g_dn < $signed((GW+2)'(r_floor))) begin
                g_new = floor_g;
            end else begin
                g_new = g_dn[GW-1:0];
            end
        end else if ((sum_c < lim_c) && (r_cgain < wlc_pkg::UNITY_GAIN)) begin
            if (g_up > (GW+1)'(wlc_pkg::UNITY_GAIN)) begin
                g_new = wlc_pkg::UNITY_GAIN;
            end else begin
                g_new = g_up[GW-1:0];
            end
        end
    end

    always_comb begin
        n_wpos    = r_wpos;
        n_lsum    = r_lsum;
        n_lim     = r_lim;
        n_cgain   = r_cgain;
        n_egain   = r_egain;
        n_pfull   = r_pfull;
        n_drem    = r_drem;
        n_dpos    = r_dpos;
        n_dsw     = r_dsw;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wpos;
        o_wr_data = i_sample_in;
        o_rd_addr = r_wpos;
        o_req     = '{valid: 1'b0, last: 1'b0, gain: r_egain};

        if (i_accept) begin
            if (wlc_pkg::t_kind'(i_kind) == wlc_pkg::KIND_DRAIN) begin
                if (r_drem != '0) begin
                    o_rd_addr  = r_dpos;
                    o_req.valid = 1'b1;
                    o_req.last  = (r_drem == (AW+1)'(1));
                    o_req.gain  = (r_dsw != '0) ? r_egain : r_cgain;
                    n_drem      = r_drem - (AW+1)'(1);
                    n_dpos      = r_dpos + AW'(1);
                    if (r_dsw != '0) begin
                        n_dsw = r_dsw - (AW+1)'(1);
                        if (r_dsw == (AW+1)'(1)) begin
                            n_dpos  = '0;
                            n_egain = r_cgain;
                        end
                    end
                end
            end else if (r_drem == '0) begin
                o_req.valid = r_pfull;
                o_wr_en     = 1'b1;
                n_lsum      = sum;
                n_lim       = r_lim + LIMW'(r_thr);
                n_wpos      = count[AW-1:0];
                if (close_win) begin
                    n_cgain = g_new;
                    n_lsum  = '0;
                    n_lim   = LIMW'(r_thr);
                    n_wpos  = '0;
                    if (!i_stream_last) begin
                        n_egain = g_new;
                        n_pfull = 1'b1;
                    end else begin
                        n_dsw   = tail;
                        n_dpos  = (tail != '0) ? count[AW-1:0] : '0;
                        n_drem  = tail + count;
                        n_pfull = 1'b0;
                        if (tail == '0) begin
                            n_egain = g_new;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= wlc_pkg::WINDOW_LEN_RST;
            r_thr   <= wlc_pkg::THRESHOLD_RST;
            r_floor <= wlc_pkg::GAIN_FLOOR_RST;
            r_att   <= wlc_pkg::ATTACK_STEP_RST;
            r_rel   <= wlc_pkg::RELEASE_STEP_RST;
            r_wpos  <= '0;
            r_lsum  <= '0;
            r_lim   <= LIMW'(wlc_pkg::THRESHOLD_RST);
            r_cgain <= wlc_pkg::UNITY_GAIN;
            r_egain <= wlc_pkg::UNITY_GAIN;
            r_pfull <= 1'b0;
            r_drem  <= '0;
            r_dpos  <= '0;
            r_dsw   <= '0;
        end else begin
            r_wpos  <= n_wpos;
            r_lsum  <= n_lsum;
            r_lim   <= n_lim;
            r_cgain <= n_cgain;
            r_egain <= n_egain;
            r_pfull <= n_pfull;
            r_drem  <= n_drem;
            r_dpos  <= n_dpos;
            r_dsw   <= n_dsw;
            if (i_cfg_wen) begin
                unique case (wlc_pkg::t_cfg_idx'(i_cfg_idx))
                    wlc_pkg::CFG_WINDOW_LEN: begin
                        r_wlen <= i_cfg_wdata[wlc_pkg::WLEN_BITS-1:0];
                    end
                    wlc_pkg::CFG_THRESHOLD: begin
                        r_thr <= i_cfg_wdata;
                        // limit tracks threshold times the running count
                        r_lim <= LIMW'(i_cfg_wdata) *
                                 LIMW'({1'b0, r_wpos} + (AW+1)'(1));
                    end
                    wlc_pkg::CFG_GAIN_FLOOR:   r_floor <= i_cfg_wdata;
                    wlc_pkg::CFG_ATTACK_STEP:  r_att   <= i_cfg_wdata;
                    wlc_pkg::CFG_RELEASE_STEP: r_rel   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/wlc_store.sv
// wlc_store: one-window sample buffer with registered read and its tag stage
// read-before-write at the same address; depends on wlc_pkg
`default_nettype none

module wlc_store #(
    parameter int MAX_WINDOW  = wlc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wlc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(MAX_WINDOW)-1:0] i_wr_addr,
    input  wire logic [SAMPLE_BITS-1:0]        i_wr_data,
    input  wire logic [$clog2(MAX_WINDOW)-1:0] i_rd_addr,
    input  wire wlc_pkg::t_rd_req              i_req,
    input  wire logic                          i_ready_dn,
    output logic                               o_ready,
    output logic [SAMPLE_BITS-1:0]             o_rd_data,
    output wlc_pkg::t_rd_req                   o_req
);

    logic [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_valid;
    logic                   r_last;
    logic [wlc_pkg::GAIN_BITS-1:0] r_gain;

    assign o_ready   = !r_valid || i_ready_dn;
    assign o_rd_data = r_rd_data;
    assign o_req     = '{valid: r_valid, last: r_last, gain: r_gain};

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_last <= i_req.last;
            r_gain <= i_req.gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_req.valid;
        end
    end

endmodule

`default_nettype wire

// File: hdl/wlc_scale.sv
// wlc_scale: gain multiply, round half up, saturate, and the output register
// two stages with their own valid bits; depends on wlc_pkg
`default_nettype none

module wlc_scale #(
    parameter int SAMPLE_BITS = wlc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    input  wire wlc_pkg::t_rd_req              i_req,
    input  wire logic                          i_stall,
    output logic                               o_ready,
    output logic                               o_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                               o_stream_end
);

    localparam int PW = SAMPLE_BITS + wlc_pkg::GAIN_BITS + 1;
    localparam int RW = PW - wlc_pkg::FRAC_BITS;

    logic signed [PW-1:0] r_prod;
    logic                 r_valid;
    logic                 r_last;
    logic                 ready_out;

    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          biased;
    logic signed [RW-1:0]          rounded;
    logic signed [SAMPLE_BITS-1:0] sat;

    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (SAMPLE_BITS-1)));

    assign ready_out = !o_valid || !i_stall;
    assign o_ready   = !r_valid || ready_out;

    assign prod    = PW'($signed(i_sample)) * $signed({1'b0, i_req.gain});
    assign biased  = r_prod + $signed(PW'(wlc_pkg::ROUND_BIAS));
    assign rounded = RW'(biased >>> wlc_pkg::FRAC_BITS);

    always_comb begin
        if (rounded > SAT_HI) begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rounded < SAT_LO) begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat = rounded[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_prod <= prod;
            r_last <= i_req.last;
        end
        if (ready_out) begin
            o_sample_out <= sat;
            o_stream_end <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_req.valid;
            end
            if (ready_out) begin
                o_valid <= r_valid;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for windowed_level_compressor, directed then random streams
// a window and gain tracker class predicts every output transfer; depends on wlc_pkg and hdl
module testbench;

    localparam int SW = wlc_pkg::SAMPLE_BITS_DEF;
    localparam int STORE_DEPTH = wlc_pkg::MAX_WINDOW_DEF;
    localparam int CDW = wlc_pkg::CFG_DATA_BITS;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 125;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;

    typedef logic signed [SW-1:0] t_sample;

    typedef struct {
        t_sample sample;
        logic    stream_end;
    } t_out_item;

    typedef enum {LEVEL_QUIET, LEVEL_WIDE, LEVEL_PEAK} t_level;

    class gain_window_tracker;
        logic [wlc_pkg::WLEN_BITS-1:0] window_len;
        logic [CDW-1:0]           threshold;
        logic [CDW-1:0]           gain_floor;
        logic [CDW-1:0]           attack_step;
        logic [CDW-1:0]           release_step;
        t_sample                  store [STORE_DEPTH];
        int unsigned              write_pos;
        int unsigned              drain_left;
        int unsigned              drain_pos;
        int unsigned              switch_left;
        longint                   level_sum;
        int                       cur_gain;
        int                       emit_gain;
        bit                       prior_full;
        t_out_item                pending_outputs [$];
        int unsigned              checked;
        int unsigned              failures;

        function new();
            window_len = wlc_pkg::WINDOW_LEN_RST;
            threshold = wlc_pkg::THRESHOLD_RST;
            gain_floor = wlc_pkg::GAIN_FLOOR_RST;
            attack_step = wlc_pkg::ATTACK_STEP_RST;
            release_step = wlc_pkg::RELEASE_STEP_RST;
            cur_gain = int'(wlc_pkg::UNITY_GAIN);
            emit_gain = int'(wlc_pkg::UNITY_GAIN);
        endfunction

        function int unsigned clamp_window(int unsigned raw);
            if (raw == 0) return 1;
            if (raw > STORE_DEPTH) return STORE_DEPTH;
            return raw;
        endfunction

        function int unsigned eff_window();
            return clamp_window(window_len);
        endfunction

        function void set_reg(wlc_pkg::t_cfg_idx idx, logic [CDW-1:0] val);
            case (idx)
                wlc_pkg::CFG_WINDOW_LEN:   window_len = val[wlc_pkg::WLEN_BITS-1:0];
                wlc_pkg::CFG_THRESHOLD:    threshold = val;
                wlc_pkg::CFG_GAIN_FLOOR:   gain_floor = val;
                wlc_pkg::CFG_ATTACK_STEP:  attack_step = val;
                wlc_pkg::CFG_RELEASE_STEP: release_step = val;
                default: ;
            endcase
        endfunction

        // rounded product, ties up, clamped to the sample range
        function t_sample scaled(t_sample s, int g);
            longint v;
            longint hi;
            hi = (longint'(1) <<< (SW - 1)) - 1;
            v = (longint'(s) * g + longint'(wlc_pkg::ROUND_BIAS)) >>> wlc_pkg::FRAC_BITS;
            if (v > hi) v = hi;
            if (v < -hi - 1) v = -hi - 1;
            return t_sample'(v);
        endfunction

        // returns 1 when the item changes state or yields an output
        function bit accept_item(wlc_pkg::t_kind k, t_sample s, logic last);
            t_out_item   r;
            int unsigned wl;
            int unsigned p;
            int unsigned cnt;
            int unsigned tail;
            int          sv;
            int          g;
            longint      limit;
            wl = eff_window();
            if (k == wlc_pkg::KIND_DRAIN) begin
                if (drain_left == 0) return 1'b0;
                r.sample = scaled(store[drain_pos], switch_left > 0 ? emit_gain : cur_gain);
                drain_left--;
                r.stream_end = (drain_left == 0);
                pending_outputs.push_back(r);
                if (switch_left > 0) begin
                    switch_left--;
                    if (switch_left == 0) begin
                        drain_pos = 0;
                        emit_gain = cur_gain;
                    end else begin
                        drain_pos = (drain_pos + 1) % STORE_DEPTH;
                    end
                end else begin
                    drain_pos = (drain_pos + 1) % STORE_DEPTH;
                end
                return 1'b1;
            end
            if (drain_left != 0) return 1'b0;
            p = write_pos;
            cnt = p + 1;
            if (prior_full) begin
                r.sample = scaled(store[p], emit_gain);
                r.stream_end = 1'b0;
                pending_outputs.push_back(r);
            end
            store[p] = s;
            sv = s;
            level_sum += (sv < 0) ? -sv : sv;
            if (last || cnt >= wl) begin
                limit = longint'(threshold) * longint'(cnt);
                g = cur_gain;
                if (level_sum > limit && g > int'(gain_floor)) begin
                    g -= int'(attack_step);
                    if (g < int'(gain_floor)) g = int'(gain_floor);
                end else if (level_sum < limit && g < int'(wlc_pkg::UNITY_GAIN)) begin
                    g += int'(release_step);
                    if (g > int'(wlc_pkg::UNITY_GAIN)) g = int'(wlc_pkg::UNITY_GAIN);
                end
                cur_gain = g;
                level_sum = 0;
                write_pos = 0;
                if (!last) begin
                    emit_gain = cur_gain;
                    prior_full = 1'b1;
                end else begin
                    tail = (prior_full && cnt < wl) ? wl - cnt : 0;
                    switch_left = tail;
                    drain_pos = (tail > 0) ? cnt : 0;
                    drain_left = tail + cnt;
                    if (tail == 0) emit_gain = cur_gain;
                    prior_full = 1'b0;
                end
            end else begin
                write_pos = cnt;
            end
            return 1'b1;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_output(t_sample got, logic got_end);
            t_out_item want;
            if (pending_outputs.size() == 0) begin
                flag($sformatf("output with none expected: sample_out %0d stream_end %b",
                               got, got_end));
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            if (got !== want.sample)
                flag($sformatf("sample_out %0d, expected %0d", got, want.sample));
            if (got_end !== want.stream_end)
                flag($sformatf("stream_end %b, expected %b", got_end, want.stream_end));
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_wen;
    logic [wlc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CDW-1:0]                    i_cfg_wdata;
    logic                              i_valid;
    logic                              o_stall;
    logic                              i_kind;
    t_sample                           i_sample_in;
    logic                              i_stream_last;
    logic                              o_valid;
    logic                              i_stall;
    t_sample                           o_sample_out;
    logic                              o_stream_end;

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned cycle_count;
    int unsigned items_done;
    int unsigned streams_done;
    int unsigned settings_done;
    gain_window_tracker tracker;

    windowed_level_compressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_sample_in   (i_sample_in),
        .i_stream_last (i_stream_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_out  (o_sample_out),
        .o_stream_end  (o_stream_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tracker.check_output(o_sample_out, o_stream_end);
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d outputs outstanding", cycle_count,
                 tracker.pending_outputs.size());
        $display("Regression FAIL");
        $finish;
    end

    // valid stays up between back-to-back transfers
    task automatic send_item(input wlc_pkg::t_kind k, input t_sample s, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= k;
        i_sample_in <= s;
        i_stream_last <= last;
        do @(posedge i_clk); while (o_stall);
        if (tracker.accept_item(k, s, last)) items_done++;
        @(negedge i_clk);
    endtask

    task automatic drain_stream();
        while (tracker.drain_left != 0) begin
            if ($urandom_range(9) == 0)
                send_item(wlc_pkg::KIND_SAMPLE, t_sample'($urandom), 1'($urandom));
            else
                send_item(wlc_pkg::KIND_DRAIN, t_sample'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tracker.pending_outputs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [CDW-1:0] wl, thr, flr, atk, rel);
        wlc_pkg::t_cfg_idx order [5];
        logic [CDW-1:0]    vals [5];
        order = '{wlc_pkg::CFG_WINDOW_LEN, wlc_pkg::CFG_THRESHOLD, wlc_pkg::CFG_GAIN_FLOOR,
                  wlc_pkg::CFG_ATTACK_STEP, wlc_pkg::CFG_RELEASE_STEP};
        vals = '{wl, thr, flr, atk, rel};
        foreach (order[i]) begin
            i_cfg_wen <= 1'b1;
            i_cfg_idx <= order[i];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            tracker.set_reg(order[i], vals[i]);
            @(negedge i_clk);
        end
        i_cfg_wen <= 1'b0;
        settings_done++;
    endtask

    task automatic random_settings();
        logic [CDW-1:0] wl;
        logic [CDW-1:0] thr;
        logic [CDW-1:0] flr;
        logic [CDW-1:0] atk;
        logic [CDW-1:0] rel;
        int unsigned    cap;
        case ($urandom_range(7))
            0: wl = '0;
            1: wl = 16'd8191;
            2: wl = CDW'(STORE_DEPTH);
            default: wl = CDW'($urandom_range(1, 12));
        endcase
        // a buffered window must not grow, its upper entries may never have been written
        if (tracker.prior_full) begin
            cap = tracker.eff_window();
            if (tracker.clamp_window(wl) > cap) wl = CDW'($urandom_range(1, cap));
        end
        case ($urandom_range(5))
            0: thr = '0;
            1: thr = 16'd32768;
            2: thr = 16'hffff;
            default: thr = CDW'($urandom_range(0, 20000));
        endcase
        case ($urandom_range(5))
            0: flr = '0;
            1: flr = 16'd32768;
            2: flr = 16'hffff;
            default: flr = CDW'($urandom_range(0, 32768));
        endcase
        case ($urandom_range(5))
            0: atk = '0;
            1: atk = 16'd32768;
            2: atk = 16'hffff;
            default: atk = CDW'($urandom_range(0, 4096));
        endcase
        case ($urandom_range(5))
            0: rel = '0;
            1: rel = 16'd32768;
            2: rel = 16'hffff;
            default: rel = CDW'($urandom_range(0, 4096));
        endcase
        program_regs(wl, thr, flr, atk, rel);
    endtask

    task automatic random_phase(input int unsigned idle, input int unsigned stall);
        int unsigned target;
        int unsigned len;
        int unsigned wl;
        t_level      mode;
        t_sample     s;
        idle_pct = idle;
        stall_pct = stall;
        target = items_done + ITEMS_PER_PHASE;
        while (items_done < target) begin
            if ($urandom_range(99) < 15) begin
                send_item(wlc_pkg::t_kind'($urandom_range(1)), t_sample'($urandom),
                          1'($urandom));
            end else begin
                drain_stream();
                wl = tracker.eff_window();
                len = $urandom_range(1, (3 * wl + 1 < 40) ? 3 * wl + 1 : 40);
                mode = LEVEL_WIDE;
                for (int unsigned n = 0; n < len; n++) begin
                    if (n % wl == 0) mode = t_level'($urandom_range(2));
                    case (mode)
                        LEVEL_QUIET: s = t_sample'(int'($urandom_range(0, 511)) - 256);
                        LEVEL_PEAK:  s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                        default:     s = t_sample'($urandom);
                    endcase
                    send_item(wlc_pkg::KIND_SAMPLE, s, n == len - 1);
                end
                drain_stream();
                streams_done++;
            end
        end
        // sometimes leave a stream open across the register change
        if ($urandom_range(1))
            repeat ($urandom_range(1, 6))
                send_item(wlc_pkg::KIND_SAMPLE, t_sample'($urandom), 1'b0);
    endtask

    initial begin
        t_sample     opening [5];
        int unsigned idle_plan [4];
        int unsigned stall_plan [4];
        opening = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, -16'sd7};
        idle_plan = '{0, 80, 0, 29};
        stall_plan = '{0, 0, 80, 29};
        tracker = new();
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = wlc_pkg::CFG_WINDOW_LEN;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_kind = wlc_pkg::KIND_SAMPLE;
        i_sample_in = '0;
        i_stream_last = 1'b0;
        i_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // loud then quiet window, short closing window, drains
        program_regs(16'd2, 16'd100, 16'd8192, 16'd4096, 16'd2048);
        send_item(wlc_pkg::KIND_DRAIN, '0, 1'b0);
        foreach (opening[i]) send_item(wlc_pkg::KIND_SAMPLE, opening[i], i == 4);
        send_item(wlc_pkg::KIND_SAMPLE, 16'sh1234, 1'b1);
        drain_stream();
        send_item(wlc_pkg::KIND_DRAIN, 16'shffff, 1'b1);

        // zero window length, gain floor above unity
        wait_idle();
        program_regs(16'd0, 16'd0, 16'hffff, 16'hffff, 16'hffff);
        send_item(wlc_pkg::KIND_SAMPLE, 16'sh8000, 1'b0);
        send_item(wlc_pkg::KIND_SAMPLE, 16'sh7fff, 1'b1);
        drain_stream();

        // window length above the store depth
        wait_idle();
        program_regs(16'd8191, 16'd32768, 16'd0, 16'd32768, 16'd32768);
        send_item(wlc_pkg::KIND_SAMPLE, 16'sh0007, 1'b0);
        send_item(wlc_pkg::KIND_SAMPLE, -16'sd9, 1'b1);
        drain_stream();

        // shorter window while a stream is open
        wait_idle();
        program_regs(16'd3, 16'd50, 16'd0, 16'd32768, 16'd32768);
        repeat (5) send_item(wlc_pkg::KIND_SAMPLE, t_sample'($urandom), 1'b0);
        wait_idle();
        program_regs(16'd2, 16'd50, 16'd0, 16'd32768, 16'd32768);
        send_item(wlc_pkg::KIND_SAMPLE, t_sample'($urandom), 1'b1);
        drain_stream();

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            random_settings();
            random_phase(idle_plan[ph % 4], stall_plan[ph % 4]);
        end
        wait_idle();

        $display("run covered %0d items in %0d random streams over %0d register settings",
                 items_done, streams_done, settings_done);
        $display("%0d output transfers checked, %0d mismatches", tracker.checked,
                 tracker.failures);
        if (tracker.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
